// ===== hdl/ppc_pkg.sv =====
// Package for the path obstacle proximity check.
// Holds the shared widths, defaults, item codes and the command word types.
// Depends on nothing.
package ppc_pkg;

    localparam int COORD_W = 32;
    localparam int RADIUS_W = 16;
    localparam int COUNT_W = 16;
    localparam int INDEX_W = 6;
    localparam int OP_W = 2;

    localparam int MAX_PATH_POINTS_DEF = 1024;
    localparam int MAX_OBSTACLES_DEF = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1450;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 2'd0,
        OP_APPEND    = 2'd1,
        OP_OBSTACLE  = 2'd2,
        OP_END_FRAME = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        t_op    op;
        t_point pt;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

// ===== hdl/path_obstacle_proximity_check.sv =====
// Top level of the path obstacle proximity check.
// Holds the radius register and joins the front stage, command queue and back stage.
// Depends on ppc_pkg, ppc_front, ppc_queue and ppc_back.
//
// Input words carry an op code and one point: clear the path, append a path
// point, test an obstacle point, or end the frame. A word is taken when i_valid
// is high and o_stall is low. Only the end-of-frame word yields an output word,
// offered on o_valid and taken when i_stall is low; it carries the found flag,
// the index of the first hitting obstacle and the count of consecutive hit frames.
// The radius is written through i_cfg_valid and i_cfg_data; o_cfg_ready is always
// high, and the radius must only be changed while the block is idle.
// Clear, append and end-of-frame words are handled without leaving the idle state
// of the back stage. An obstacle that must be tested walks the stored path one
// point per cycle and holds the back stage until the walk is done, or until a hit
// ends the walk early.
// An end-of-frame word passes through the input register and the command queue,
// and its result is registered in the back stage.
// A four-word queue behind a one-word input register lets new words enter while
// the back stage scans or while a finished result waits under i_stall.
// Synchronous reset empties the path and frame state, clears the hit count and
// loads a radius of 1450 mm; the path store itself is not cleared.
module path_obstacle_proximity_check #(
    parameter int MAX_PATH_POINTS = ppc_pkg::MAX_PATH_POINTS_DEF,
    parameter int MAX_OBSTACLES   = ppc_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ppc_pkg::OP_W-1:0]              i_op,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_point_x,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_point_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_obstacle_found,
    output logic [ppc_pkg::INDEX_W-1:0]           o_first_obstacle_index,
    output logic [ppc_pkg::COUNT_W-1:0]           o_hit_count,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ppc_pkg::RADIUS_W-1:0]          i_cfg_data
);
    import ppc_pkg::*;

    logic [RADIUS_W-1:0] r_hit_radius;
    t_cmd_q              w_push;
    t_cmd_q              w_head;
    logic                w_q_full;
    logic                w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_radius <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hit_radius <= i_cfg_data;
        end
    end

    ppc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_op      (i_op),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_q_full  (w_q_full),
        .o_push    (w_push)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    ppc_back #(
        .MAX_PATH_POINTS (MAX_PATH_POINTS),
        .MAX_OBSTACLES   (MAX_OBSTACLES)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_head                 (w_head),
        .o_pop                  (w_pop),
        .i_hit_radius           (r_hit_radius),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_obstacle_found       (o_obstacle_found),
        .o_first_obstacle_index (o_first_obstacle_index),
        .o_hit_count            (o_hit_count)
    );

endmodule

// ===== hdl/ppc_front.sv =====
// Front stage of the proximity check: takes input words and decodes them.
// Decoded command words are offered to the command queue.
// Depends on ppc_pkg.
module ppc_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [ppc_pkg::OP_W-1:0]              i_op,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_point_x,
    input  logic signed [ppc_pkg::COORD_W-1:0]    i_point_y,
    input  logic                                  i_q_full,
    output ppc_pkg::t_cmd_q                       o_push
);
    import ppc_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_stall = r_valid & i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd.op   <= t_op'(i_op);
            r_cmd.pt.x <= i_point_x;
            r_cmd.pt.y <= i_point_y;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.cmd   = r_cmd;

endmodule

// ===== hdl/ppc_queue.sv =====
// Short command queue between the front and back stages of the proximity check.
// A register-based FIFO of QUEUE_DEPTH command words.
// Depends on ppc_pkg.
module ppc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppc_pkg::t_cmd_q  i_push,
    output logic             o_full,
    output ppc_pkg::t_cmd_q  o_head,
    input  logic             i_pop
);
    import ppc_pkg::*;

    t_cmd                   r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr;
    logic [QUEUE_AW:0]      r_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_full = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push = i_push.valid & ~o_full;
    assign w_pop  = i_pop & o_head.valid;

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

// ===== hdl/ppc_back.sv =====
// Back stage of the proximity check: path store, distance scan and frame results.
// Walks the stored path one point per cycle through a distance pipeline.
// Depends on ppc_pkg.
module ppc_back #(
    parameter int MAX_PATH_POINTS = ppc_pkg::MAX_PATH_POINTS_DEF,
    parameter int MAX_OBSTACLES   = ppc_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppc_pkg::t_cmd_q                  i_head,
    output logic                             o_pop,
    input  logic [ppc_pkg::RADIUS_W-1:0]     i_hit_radius,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_obstacle_found,
    output logic [ppc_pkg::INDEX_W-1:0]      o_first_obstacle_index,
    output logic [ppc_pkg::COUNT_W-1:0]      o_hit_count
);
    import ppc_pkg::*;

    localparam int AW = $clog2(MAX_PATH_POINTS);
    localparam int LW = $clog2(MAX_PATH_POINTS + 1);
    localparam int PW = $clog2(MAX_OBSTACLES + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                  r_state;
    logic [LW-1:0]           r_len;
    logic [PW-1:0]           r_pos;
    logic                    r_frame_hit;
    logic [PW-1:0]           r_hit_index;
    logic [COUNT_W-1:0]      r_count;
    logic [LW-1:0]           r_issue;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    t_point                  r_obs;
    logic [PW-1:0]           r_cur_pos;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [INDEX_W-1:0]      r_out_index;
    logic [COUNT_W-1:0]      r_out_count;

    t_point                  r_path [MAX_PATH_POINTS];
    t_point                  r_rd;
    logic [2*RADIUS_W-1:0]   r_r2;
    logic [15:0]             r_dx;
    logic [15:0]             r_dy;
    logic                    r_far2;
    logic [31:0]             r_sqx;
    logic [31:0]             r_sqy;
    logic                    r_far3;

    logic                    w_wr_en;
    logic                    w_end_pop;
    logic [COORD_W:0]        w_ox;
    logic [COORD_W:0]        w_oy;
    logic [COORD_W:0]        w_px;
    logic [COORD_W:0]        w_py;
    logic [COORD_W:0]        w_adx;
    logic [COORD_W:0]        w_ady;
    logic [32:0]             w_sum;
    logic                    w_hit;
    logic                    w_found;
    logic [PW+INDEX_W-1:0]   w_idx_ext;
    logic [COUNT_W-1:0]      w_count_inc;

    assign o_pop = (r_state == ST_IDLE) && i_head.valid &&
                   (i_head.cmd.op != OP_END_FRAME || !r_out_valid || !i_stall);

    assign w_wr_en = o_pop && (i_head.cmd.op == OP_APPEND) &&
                     (r_len < LW'(MAX_PATH_POINTS));

    assign w_end_pop = o_pop && (i_head.cmd.op == OP_END_FRAME);

    always_comb begin
        w_ox  = {r_obs.x[COORD_W-1], r_obs.x};
        w_oy  = {r_obs.y[COORD_W-1], r_obs.y};
        w_px  = {r_rd.x[COORD_W-1], r_rd.x};
        w_py  = {r_rd.y[COORD_W-1], r_rd.y};
        w_adx = ($signed(r_obs.x) >= $signed(r_rd.x)) ? (w_ox - w_px) : (w_px - w_ox);
        w_ady = ($signed(r_obs.y) >= $signed(r_rd.y)) ? (w_oy - w_py) : (w_py - w_oy);
    end

    assign w_sum       = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_hit       = r_v3 && !r_far3 && (w_sum < {1'b0, r_r2});
    assign w_found     = (r_len != '0) && (r_pos != '0) && r_frame_hit;
    assign w_idx_ext   = {{INDEX_W{1'b0}}, r_hit_index};
    assign w_count_inc = (r_count != '1) ? (r_count + 1'b1) : r_count;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_path[r_len[AW-1:0]] <= i_head.cmd.pt;
        end
        r_rd   <= r_path[r_issue[AW-1:0]];
        r_r2   <= {{RADIUS_W{1'b0}}, i_hit_radius} * {{RADIUS_W{1'b0}}, i_hit_radius};
        r_dx   <= w_adx[15:0];
        r_dy   <= w_ady[15:0];
        r_far2 <= (w_adx[COORD_W:16] != '0) || (w_ady[COORD_W:16] != '0);
        r_sqx  <= {16'd0, r_dx} * {16'd0, r_dx};
        r_sqy  <= {16'd0, r_dy} * {16'd0, r_dy};
        r_far3 <= r_far2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_pos       <= '0;
            r_frame_hit <= 1'b0;
            r_hit_index <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_obs       <= '0;
            r_cur_pos   <= '0;
            r_out_valid <= 1'b0;
            r_out_found <= 1'b0;
            r_out_index <= '0;
            r_out_count <= '0;
        end else begin
            if (r_out_valid && !i_stall && !w_end_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_head.cmd.op)
                            OP_CLEAR: begin
                                r_len <= '0;
                            end
                            OP_APPEND: begin
                                if (w_wr_en) begin
                                    r_len <= r_len + 1'b1;
                                end
                            end
                            OP_OBSTACLE: begin
                                if (r_pos < PW'(MAX_OBSTACLES)) begin
                                    r_pos <= r_pos + 1'b1;
                                    if (!r_frame_hit && r_len != '0) begin
                                        r_obs     <= i_head.cmd.pt;
                                        r_cur_pos <= r_pos;
                                        r_issue   <= '0;
                                        r_state   <= ST_SCAN;
                                    end
                                end
                            end
                            OP_END_FRAME: begin
                                r_out_valid <= 1'b1;
                                r_out_found <= w_found;
                                r_out_index <= w_found ? w_idx_ext[INDEX_W-1:0] : '0;
                                r_out_count <= w_found ? w_count_inc : '0;
                                r_count     <= w_found ? w_count_inc : '0;
                                r_pos       <= '0;
                                r_frame_hit <= 1'b0;
                                r_hit_index <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_frame_hit <= 1'b1;
                        r_hit_index <= r_cur_pos;
                        r_v1        <= 1'b0;
                        r_v2        <= 1'b0;
                        r_v3        <= 1'b0;
                        r_state     <= ST_IDLE;
                    end else begin
                        if (r_issue != r_len) begin
                            r_issue <= r_issue + 1'b1;
                            r_v1    <= 1'b1;
                        end else begin
                            r_v1 <= 1'b0;
                        end
                        r_v2 <= r_v1;
                        r_v3 <= r_v2;
                        if (r_issue == r_len && !r_v1 && !r_v2 && !r_v3) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid                = r_out_valid;
    assign o_obstacle_found       = r_out_found;
    assign o_first_obstacle_index = r_out_index;
    assign o_hit_count            = r_out_count;

endmodule
